@@ rtl/rob_pkg.sv @@
// Shared types and constants for the reorder buffer.
package rob_pkg;

  localparam int unsigned RobDepth = 16;
  localparam int unsigned IdxW     = 4;   // log2(RobDepth); pointers wrap naturally
  localparam int unsigned CntW     = 5;   // holds 0..RobDepth
  localparam int unsigned PcW      = 16;
  localparam int unsigned ArchW    = 4;
  localparam int unsigned PhysW    = 5;
  localparam int unsigned ValW     = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_COMMIT   = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NO_COMMIT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ALLOC,
    OP_FULL,
    OP_COMPLETE,
    OP_COMMIT,
    OP_NO_COMMIT
  } op_e;

  typedef enum logic {
    OB_EMPTY,
    OB_FULL
  } obuf_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } rob_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic head_done;
  } rob_stat_t;

endpackage

@@ rtl/rob_ctrl.sv @@
// Reorder buffer controller: handshake, output-register state and op decode.
module rob_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [rob_pkg::ModeW-1:0]   mode_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  input  rob_pkg::rob_stat_t          stat_i,
  output rob_pkg::rob_cmd_t           cmd_o
);

  rob_pkg::obuf_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rob_pkg::OB_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rob_pkg::OB_EMPTY: begin
        if (s_tvalid_i) state_d = rob_pkg::OB_FULL;
      end
      rob_pkg::OB_FULL: begin
        if (m_tready_i && !s_tvalid_i) state_d = rob_pkg::OB_EMPTY;
      end
      default: state_d = rob_pkg::OB_EMPTY;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o  = (state_q == rob_pkg::OB_EMPTY) || m_tready_i;
    m_tvalid_o  = (state_q == rob_pkg::OB_FULL);
    cmd_o.load  = s_tvalid_i && s_tready_o;
    cmd_o.op    = rob_pkg::OP_NOP;
    unique case (rob_pkg::mode_e'(mode_i))
      rob_pkg::MODE_ALLOC:
        cmd_o.op = stat_i.full ? rob_pkg::OP_FULL : rob_pkg::OP_ALLOC;
      rob_pkg::MODE_COMPLETE:
        cmd_o.op = rob_pkg::OP_COMPLETE;
      rob_pkg::MODE_COMMIT:
        cmd_o.op = (stat_i.empty || !stat_i.head_done) ? rob_pkg::OP_NO_COMMIT
                                                        : rob_pkg::OP_COMMIT;
      rob_pkg::MODE_NONE:
        cmd_o.op = rob_pkg::OP_NOP;
      default:
        cmd_o.op = rob_pkg::OP_NOP;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> m_tvalid_o)
    else $error("accepted beat did not reach output register");
  a_no_alloc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.full |-> cmd_o.op != rob_pkg::OP_ALLOC)
    else $error("allocate decoded while buffer full");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
    else $error("stalled result dropped");
`endif

endmodule

@@ rtl/rob_dp.sv @@
// Reorder buffer datapath: entry storage, pointers, count and result register.
module rob_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rob_pkg::rob_cmd_t             cmd_i,
  output rob_pkg::rob_stat_t            stat_o,
  input  logic [rob_pkg::PcW-1:0]       instr_pc_i,
  input  logic [rob_pkg::ArchW-1:0]     arch_dest_i,
  input  logic [rob_pkg::IdxW-1:0]      entry_index_i,
  input  logic signed [rob_pkg::ValW-1:0] result_value_i,
  input  logic                          was_mispredicted_i,
  output logic [rob_pkg::StatusW-1:0]   status_o,
  output logic [rob_pkg::IdxW-1:0]      alloc_index_o,
  output logic                          commit_valid_o,
  output logic [rob_pkg::ArchW-1:0]     commit_arch_reg_o,
  output logic signed [rob_pkg::ValW-1:0] commit_value_o,
  output logic                          clear_zero_flag_o,
  output logic [rob_pkg::PcW-1:0]       commit_pc_o,
  output logic [rob_pkg::CntW-1:0]      occupancy_o
);

  // entry payload (no reset, written before any read that reaches the output)
  logic [rob_pkg::PcW-1:0]   pc_mem   [rob_pkg::RobDepth];
  logic [rob_pkg::ArchW-1:0] arch_mem [rob_pkg::RobDepth];
  logic [rob_pkg::ValW-1:0]  val_mem  [rob_pkg::RobDepth];

  logic [rob_pkg::RobDepth-1:0] done_q, mispred_q;
  logic [rob_pkg::IdxW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [rob_pkg::CntW-1:0]     count_q, count_d;

  logic [rob_pkg::StatusW-1:0]  status_d;
  logic [rob_pkg::IdxW-1:0]     alloc_index_d;
  logic                         commit_valid_d, clear_zf_d;

  assign stat_o.full      = (count_q == rob_pkg::CntW'(rob_pkg::RobDepth));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.head_done = done_q[head_q];

  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    status_d       = rob_pkg::STAT_OK;
    alloc_index_d  = '0;
    commit_valid_d = 1'b0;
    clear_zf_d     = 1'b0;
    case (cmd_i.op)
      rob_pkg::OP_ALLOC: begin
        alloc_index_d = tail_q;
        tail_d        = tail_q + rob_pkg::IdxW'(1);   // depth is 2**IdxW
        count_d       = count_q + rob_pkg::CntW'(1);
      end
      rob_pkg::OP_FULL:      status_d = rob_pkg::STAT_FULL;
      rob_pkg::OP_NO_COMMIT: status_d = rob_pkg::STAT_NO_COMMIT;
      rob_pkg::OP_COMMIT: begin
        commit_valid_d = 1'b1;
        clear_zf_d     = mispred_q[head_q];
        head_d         = head_q + rob_pkg::IdxW'(1);
        count_d        = count_q - rob_pkg::CntW'(1);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      done_q    <= '0;
      mispred_q <= '0;
    end else if (cmd_i.load) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cmd_i.op == rob_pkg::OP_ALLOC) begin
        done_q[tail_q]    <= 1'b0;
        mispred_q[tail_q] <= 1'b0;
      end else if (cmd_i.op == rob_pkg::OP_COMPLETE) begin
        done_q[entry_index_i]    <= 1'b1;
        mispred_q[entry_index_i] <= was_mispredicted_i;
      end
    end
  end

  // entry payload and result register; head entry read straight into the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cmd_i.op == rob_pkg::OP_ALLOC) begin
        pc_mem[tail_q]   <= instr_pc_i;
        arch_mem[tail_q] <= arch_dest_i;
      end
      if (cmd_i.op == rob_pkg::OP_COMPLETE) begin
        val_mem[entry_index_i] <= result_value_i;
      end
      status_o          <= status_d;
      alloc_index_o     <= alloc_index_d;
      commit_valid_o    <= commit_valid_d;
      commit_arch_reg_o <= commit_valid_d ? arch_mem[head_q] : '0;
      commit_value_o    <= commit_valid_d ? val_mem[head_q] : '0;
      clear_zero_flag_o <= clear_zf_d;
      commit_pc_o       <= commit_valid_d ? pc_mem[head_q] : '0;
      occupancy_o       <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rob_pkg::CntW'(rob_pkg::RobDepth))
    else $error("entry count above depth");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == rob_pkg::IdxW'(head_q + count_q[rob_pkg::IdxW-1:0]))
    else $error("head, tail and count disagree");
  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && cmd_i.op == rob_pkg::OP_COMMIT) |-> (done_q[head_q] && count_q != '0))
    else $error("retired an entry that was not done");
`endif

endmodule

@@ rtl/reorder_buffer.sv @@
// Reorder buffer top level: stream ports, controller and datapath.
//
//  channel | dir | tdata / tuser                                    | accept
//  s_axis  | in  | tuser: mode; tdata: pc, arch, phys, index, value, mis | tvalid & tready
//  m_axis  | out | tuser: status; tdata: commit and occupancy fields  | tvalid & tready
//
// Each beat is executed in the cycle it is accepted: the pointer, count and
// done-mark update is one step, so one beat per cycle is taken while the master side does not stall.
// The result lands in a one-beat output register; a new beat is accepted while
// that register is empty or being drained in the same cycle.
// A stalled master side holds the result and stops input until it is taken.
// Reset (async, active low) clears head, tail, count, done and mispredict
// marks and the output valid; entry payload is not reset. No clearing pass.
module reorder_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] instr_pc, [19:16] arch_dest, [24:20] phys_dest, [28:25] entry_index,
  // [60:29] result_value, [61] was_mispredicted, [63:62] zero
  input  logic [rob_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [rob_pkg::ModeW-1:0]    s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] alloc_index, [4] commit_valid, [8:5] commit_arch_reg,
  // [40:9] commit_value, [41] clear_zero_flag, [57:42] commit_pc,
  // [62:58] occupancy, [63] zero
  output logic [rob_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [rob_pkg::StatusW-1:0]  m_axis_tuser
);

  rob_pkg::rob_cmd_t  cmd;
  rob_pkg::rob_stat_t stat;

  logic [rob_pkg::IdxW-1:0]        alloc_index;
  logic                            commit_valid;
  logic [rob_pkg::ArchW-1:0]       commit_arch_reg;
  logic signed [rob_pkg::ValW-1:0] commit_value;
  logic                            clear_zero_flag;
  logic [rob_pkg::PcW-1:0]         commit_pc;
  logic [rob_pkg::CntW-1:0]        occupancy;

  rob_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // phys_dest (tdata[24:20]) is never reported at commit, so it is not kept.
  rob_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .instr_pc_i         (s_axis_tdata[15:0]),
    .arch_dest_i        (s_axis_tdata[19:16]),
    .entry_index_i      (s_axis_tdata[28:25]),
    .result_value_i     (s_axis_tdata[60:29]),
    .was_mispredicted_i (s_axis_tdata[61]),
    .status_o           (m_axis_tuser),
    .alloc_index_o      (alloc_index),
    .commit_valid_o     (commit_valid),
    .commit_arch_reg_o  (commit_arch_reg),
    .commit_value_o     (commit_value),
    .clear_zero_flag_o  (clear_zero_flag),
    .commit_pc_o        (commit_pc),
    .occupancy_o        (occupancy)
  );

  assign m_axis_tdata = {1'b0, occupancy, commit_pc, clear_zero_flag, commit_value,
                         commit_arch_reg, commit_valid, alloc_index};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the reorder buffer: shadow model, stream drivers, checker.
`timescale 1ns / 1ps

// One input beat, unpacked into its fields.
typedef struct packed {
  rob_pkg::mode_e mode;
  logic [15:0]    pc;
  logic [3:0]     arch;
  logic [4:0]     phys;
  logic [3:0]     index;
  logic [31:0]    value;
  logic           mispredict;
} rob_op_t;

// One output beat as the buffer should produce it.
typedef struct packed {
  rob_pkg::status_e status;
  logic [3:0]       alloc_index;
  logic             commit_valid;
  logic [3:0]       commit_arch;
  logic [31:0]      commit_value;
  logic             clear_zero;
  logic [15:0]      commit_pc;
  logic [4:0]       occupancy;
} rob_result_t;

// Shadow copy of the buffer: predicts each result and checks the DUT against it.
class rob_shadow;
  logic [15:0] pc_mem[rob_pkg::RobDepth];
  logic [3:0]  arch_mem[rob_pkg::RobDepth];
  logic [31:0] value_mem[rob_pkg::RobDepth];
  bit          done_mem[rob_pkg::RobDepth];
  bit          mis_mem[rob_pkg::RobDepth];
  logic [3:0]  head = '0;
  logic [3:0]  tail = '0;
  int unsigned count = 0;

  rob_result_t expected_q[$];

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned n_alloc = 0, n_full = 0, n_complete = 0, n_commit = 0;
  int unsigned n_flush = 0, n_no_commit = 0, n_unused = 0, peak = 0;

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Apply one accepted beat to the shadow state and queue the result it causes.
  function void note_op(rob_op_t op);
    rob_result_t res;
    res = '0;
    case (op.mode)
      rob_pkg::MODE_ALLOC: begin
        if (count >= rob_pkg::RobDepth) begin
          res.status = rob_pkg::STAT_FULL;
          n_full++;
        end else begin
          pc_mem[tail]    = op.pc;
          arch_mem[tail]  = op.arch;
          done_mem[tail]  = 1'b0;
          mis_mem[tail]   = 1'b0;
          res.alloc_index = tail;        // old tail, also across the wrap
          tail            = tail + 1'b1;
          count++;
          n_alloc++;
        end
      end
      rob_pkg::MODE_COMPLETE: begin
        // written even when the entry is not in flight
        value_mem[op.index] = op.value;
        mis_mem[op.index]   = op.mispredict;
        done_mem[op.index]  = 1'b1;
        n_complete++;
      end
      rob_pkg::MODE_COMMIT: begin
        if (count == 0 || !done_mem[head]) begin
          res.status = rob_pkg::STAT_NO_COMMIT;
          n_no_commit++;
        end else begin
          res.commit_valid = 1'b1;
          res.commit_arch  = arch_mem[head];
          res.commit_value = value_mem[head];
          res.clear_zero   = mis_mem[head];
          res.commit_pc    = pc_mem[head];
          if (mis_mem[head]) n_flush++;
          head = head + 1'b1;
          count--;
          n_commit++;
        end
      end
      default: n_unused++;
    endcase
    res.occupancy = 5'(count);
    if (count > peak) peak = count;
    expected_q.push_back(res);
  endfunction

  task compare(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", checked, name, got, want));
  endtask

  task check_result(logic [1:0] status, logic [63:0] data);
    rob_result_t want;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", checked));
      return;
    end
    want = expected_q.pop_front();
    compare("status",          status,       want.status);
    compare("alloc_index",     data[3:0],    want.alloc_index);
    compare("commit_valid",    data[4],      want.commit_valid);
    compare("commit_arch_reg", data[8:5],    want.commit_arch);
    compare("commit_value",    data[40:9],   want.commit_value);
    compare("clear_zero_flag", data[41],     want.clear_zero);
    compare("commit_pc",       data[57:42],  want.commit_pc);
    compare("occupancy",       data[62:58],  want.occupancy);
  endtask
endclass

module tb;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [rob_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [rob_pkg::ModeW-1:0]    s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [rob_pkg::OutDataW-1:0] m_axis_tdata;
  logic [rob_pkg::StatusW-1:0]  m_axis_tuser;

  int unsigned gap_pct   = 0;   // sender idles this often per hundred beats
  int unsigned stall_pct = 0;   // receiver stalls with this chance, in percent
  int unsigned hold_len  = 0;
  logic        holding   = 1'b0;
  event        hold_ev;

  rob_shadow rob_chk = new;

  reorder_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a solid hold-off while a back-pressure window runs.
  always @(posedge clk_i) begin
    if (holding) m_axis_tready <= 1'b0;
    else         m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Back-pressure window, counted here in clock cycles.
  initial forever begin
    @(hold_ev);
    holding <= 1'b1;
    repeat (hold_len) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      rob_chk.check_result(m_axis_tuser, m_axis_tdata);
  end

  // Present one beat (after any random idle cycles) and wait for the handshake.
  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic issue_op(input rob_op_t op);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op.mode;
    s_axis_tdata  <= {2'b00, op.mispredict, op.value, op.index, op.phys, op.arch, op.pc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rob_chk.note_op(op);
  endtask

  task automatic issue(input rob_pkg::mode_e m, input logic [15:0] pc,
                       input logic [3:0] arch, input logic [4:0] phys,
                       input logic [3:0] idx, input logic [31:0] val, input logic mis);
    rob_op_t op;
    op = '{mode: m, pc: pc, arch: arch, phys: phys, index: idx, value: val,
           mispredict: mis};
    issue_op(op);
  endtask

  // Mostly well-formed traffic: allocations, completions of in-flight entries
  // (often the head, so retirement makes progress), commits, a little noise.
  function automatic rob_op_t random_op(int unsigned alloc_w);
    rob_op_t     op;
    int unsigned pick;
    op.pc         = 16'($urandom);
    op.arch       = 4'($urandom);
    op.phys       = 5'($urandom);
    op.index      = 4'($urandom);
    op.value      = $urandom;
    op.mispredict = 1'($urandom);
    pick = $urandom_range(alloc_w + 62);
    if (pick < alloc_w) begin
      op.mode = rob_pkg::MODE_ALLOC;
    end else if (pick < alloc_w + 35) begin
      op.mode = rob_pkg::MODE_COMPLETE;
      if (rob_chk.count != 0 && $urandom_range(9) < 8) begin
        if ($urandom_range(9) < 3) op.index = rob_chk.head;
        else op.index = rob_chk.head + 4'($urandom_range(rob_chk.count - 1));
      end
    end else if (pick < alloc_w + 60) begin
      op.mode = rob_pkg::MODE_COMMIT;
    end else begin
      op.mode = rob_pkg::MODE_NONE;
    end
    return op;
  endfunction

  // One idling setting; the alloc weight swings so the buffer both fills and drains.
  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input int unsigned n);
    int unsigned alloc_w;
    gap_pct   = gap;
    stall_pct = stall;
    alloc_w   = 40;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(2))
          0:       alloc_w = 10;
          1:       alloc_w = 40;
          default: alloc_w = 80;
        endcase
      end
      issue_op(random_op(alloc_w));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty, not-done head, stale completion, unused mode, wrap, full.
    issue(rob_pkg::MODE_COMMIT,   16'hFFFF, 4'hF, 5'h1F, 4'hF, 32'hFFFF_FFFF, 1'b1);
    issue(rob_pkg::MODE_ALLOC,    16'h0000, 4'h0, 5'h00, 4'h0, 32'h0000_0000, 1'b0);
    issue(rob_pkg::MODE_COMMIT,   16'h0000, 4'h0, 5'h00, 4'h0, 32'h0000_0000, 1'b0);
    issue(rob_pkg::MODE_COMPLETE, 16'h0000, 4'h0, 5'h00, 4'h0, 32'h7FFF_FFFF, 1'b0);
    // entry 15 is not in flight yet; its marks must be cleared when allocated
    issue(rob_pkg::MODE_COMPLETE, 16'h0000, 4'h0, 5'h00, 4'hF, 32'h8000_0000, 1'b1);
    issue(rob_pkg::MODE_NONE,     16'hFFFF, 4'hF, 5'h1F, 4'hF, 32'hFFFF_FFFF, 1'b1);
    issue(rob_pkg::MODE_COMMIT,   16'h0000, 4'h0, 5'h00, 4'h0, 32'h0000_0000, 1'b0);
    // fill: tail runs 1..15 and wraps to 0
    for (int i = 0; i < 16; i++)
      issue(rob_pkg::MODE_ALLOC, i[0] ? 16'hFFFF : 16'h0000, i[0] ? 4'hF : 4'h0,
            i[0] ? 5'h1F : 5'h00, 4'hF, 32'hFFFF_FFFF, 1'b1);
    issue(rob_pkg::MODE_ALLOC,    16'hA5A5, 4'h5, 5'h0A, 4'h0, 32'h0000_0000, 1'b0);
    issue(rob_pkg::MODE_COMMIT,   16'h0000, 4'h0, 5'h00, 4'h0, 32'h0000_0000, 1'b0);
    issue(rob_pkg::MODE_COMPLETE, 16'h0000, 4'h0, 5'h00, 4'h1, 32'h8000_0000, 1'b1);
    issue(rob_pkg::MODE_COMMIT,   16'h0000, 4'h0, 5'h00, 4'h0, 32'h0000_0000, 1'b0);

    run_phase(0, 0, 130);
    run_phase(78, 0, 130);
    run_phase(0, 78, 130);
    run_phase(31, 31, 130);

    // Long receiver hold-off while beats keep coming: input must stall.
    gap_pct   = 0;
    stall_pct = 0;
    hold_len  = 300;
    -> hold_ev;
    repeat (60) issue_op(random_op(40));
    s_axis_tvalid <= 1'b0;

    while (rob_chk.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d allocations (%0d refused as full), %0d completions,",
             rob_chk.n_alloc, rob_chk.n_full, rob_chk.n_complete);
    $display("  %0d unused-mode beats; retired %0d entries (%0d mispredicted),",
             rob_chk.n_unused, rob_chk.n_commit, rob_chk.n_flush);
    $display("  %0d commits refused, peak occupancy %0d",
             rob_chk.n_no_commit, rob_chk.peak);
    if (rob_chk.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches over %0d results", rob_chk.errors, rob_chk.checked);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", rob_chk.expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rob_pkg.sv
rtl/rob_ctrl.sv
rtl/rob_dp.sv
rtl/reorder_buffer.sv
tb/tb.sv
